// ===== rtl/core/mdio_mm_pkg.sv =====
// ----------------------------------------------------------------------------
// MDIO management master package
// Transfer types, mode codes and frame constants for the clause 22 master.
// ----------------------------------------------------------------------------
package mdio_mm_pkg;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_PRE   = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [4:0]  reg_address;
    logic [15:0] write_data;
    logic        mdio_in;
  } in_item_t;

  typedef struct packed {
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;
    logic        busy_res;
    logic [15:0] read_data;
    logic        read_done;
    logic        command_refused;
  } out_item_t;

  localparam logic [15:0] HDR_READ      = 16'h6002;
  localparam logic [15:0] HDR_WRITE     = 16'h5002;
  localparam logic [31:0] PREAMBLE      = 32'hFFFF_FFFF;
  localparam logic [4:0]  PHY_ADDR_RST  = 5'd16;
  localparam logic [5:0]  HDR_READ_BITS = 6'd15;
  localparam logic [5:0]  FRAME_BITS    = 6'd32;
  localparam logic [4:0]  READ_BITS     = 5'd16;

endpackage

// ===== rtl/core/mdio_management_master_core.sv =====
// ----------------------------------------------------------------------------
// MDIO management master core
// Clause 22 frame sequencer advanced one half MDC period per tick transfer.
// ----------------------------------------------------------------------------
// Throughput: one transfer per cycle while in_ready is high (the result
// buffer not full); the frame state is updated by each accepted transfer.
// A two-entry result buffer keeps input open while one result is stalled.
// Reset (rst_n low, synchronous) clears all frame state, empties the result
// buffer and sets the PHY address to 16.
module mdio_management_master_core
  import mdio_mm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  logic [4:0]  phy_addr_r;
  logic [31:0] frame_r, frame_nxt;
  logic [5:0]  bits_left_r, bits_left_nxt;
  logic [4:0]  rd_bits_r, rd_bits_nxt;
  logic        clk_high_r, clk_high_nxt;
  logic        drive_r, drive_nxt;
  logic        is_read_r, is_read_nxt;
  logic [15:0] capture_r, capture_nxt;

  logic        busy, busy_nxt, done, refused, push, pop;
  logic [15:0] hdr;
  out_item_t   res;

  out_item_t   out_r, skid_r;
  logic        out_valid_r, skid_valid_r;

  assign busy     = (bits_left_r != '0) || (rd_bits_r != '0);
  assign in_ready = !skid_valid_r;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;
  assign hdr      = {4'b0000, phy_addr_r, in_data.reg_address, 2'b00};

  always_comb begin
    frame_nxt     = frame_r;
    bits_left_nxt = bits_left_r;
    rd_bits_nxt   = rd_bits_r;
    clk_high_nxt  = clk_high_r;
    drive_nxt     = drive_r;
    is_read_nxt   = is_read_r;
    capture_nxt   = capture_r;
    done          = 1'b0;
    refused       = 1'b0;
    if (in_data.mode != MODE_TICK) begin
      if (busy) begin
        refused = 1'b1;
      end else begin
        clk_high_nxt = 1'b0;
        drive_nxt    = 1'b1;
        unique case (in_data.mode)
          MODE_READ: begin
            frame_nxt     = {HDR_READ | hdr, 16'h0000};
            bits_left_nxt = HDR_READ_BITS;
            rd_bits_nxt   = READ_BITS;
            is_read_nxt   = 1'b1;
          end
          MODE_WRITE: begin
            frame_nxt     = {HDR_WRITE | hdr, in_data.write_data};
            bits_left_nxt = FRAME_BITS;
            rd_bits_nxt   = '0;
            is_read_nxt   = 1'b0;
          end
          default: begin
            frame_nxt     = PREAMBLE;
            bits_left_nxt = FRAME_BITS;
            rd_bits_nxt   = '0;
            is_read_nxt   = 1'b0;
          end
        endcase
      end
    end else if (busy) begin
      if (!clk_high_r) begin
        clk_high_nxt = 1'b1;
        if (bits_left_r == '0) begin
          frame_nxt = {frame_r[30:0], in_data.mdio_in};
        end
      end else begin
        clk_high_nxt = 1'b0;
        if (bits_left_r != '0) begin
          bits_left_nxt = bits_left_r - 6'd1;
          frame_nxt     = {frame_r[30:0], 1'b0};
          if (bits_left_nxt == '0 && is_read_r && rd_bits_r != '0) begin
            drive_nxt = 1'b0;
            frame_nxt = '0;
          end
        end else begin
          rd_bits_nxt = rd_bits_r - 5'd1;
          if (rd_bits_nxt == '0) begin
            capture_nxt = frame_r[15:0];
            frame_nxt   = '0;
            done        = 1'b1;
          end
        end
      end
    end
  end

  assign busy_nxt = (bits_left_nxt != '0) || (rd_bits_nxt != '0);

  always_comb begin
    res.mdc             = clk_high_nxt;
    res.mdio_out        = drive_nxt & frame_nxt[31];
    res.mdio_drive      = drive_nxt;
    res.busy_res        = busy_nxt;
    res.read_data       = capture_nxt;
    res.read_done       = done;
    res.command_refused = refused;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phy_addr_r  <= PHY_ADDR_RST;
      frame_r     <= '0;
      bits_left_r <= '0;
      rd_bits_r   <= '0;
      clk_high_r  <= 1'b0;
      drive_r     <= 1'b0;
      is_read_r   <= 1'b0;
      capture_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        phy_addr_r <= cfg_wr_data;
      end
      if (push) begin
        frame_r     <= frame_nxt;
        bits_left_r <= bits_left_nxt;
        rd_bits_r   <= rd_bits_nxt;
        clk_high_r  <= clk_high_nxt;
        drive_r     <= drive_nxt;
        is_read_r   <= is_read_nxt;
        capture_r   <= capture_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a head result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.read_done) |-> !out_r.busy_res)
    else $error("read completed while still busy");

  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bits_left_r <= FRAME_BITS) && (rd_bits_r <= READ_BITS))
    else $error("bit counter out of range");

  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_data.mode != MODE_TICK && !busy) |=> (bits_left_r != '0))
    else $error("accepted start command did not begin a sequence");

  a_refuse_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (push && refused) |-> busy)
    else $error("command refused while idle");
`endif

endmodule
